FILE: rtl/lph_pkg.sv
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types, codes and defaults for the linear probing hash table.
// ----------------------------------------------------------------------------
package lph_pkg;

    localparam int SLOTS_DEFAULT     = 1024;
    localparam int LIMIT_W           = 10;
    localparam int ENTRY_LIMIT_RESET = 512;

    localparam logic [1:0] FN_LOOKUP = 2'd0;
    localparam logic [1:0] FN_INSERT = 2'd1;
    localparam logic [1:0] FN_REMOVE = 2'd2;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_ZERO     = 2'd3;

    localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] key;
        logic [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [31:0] found_value;
    } rsp_t;

    typedef struct packed {
        logic       clr_wr;
        logic       load_req;
        logic       hash_req;
        logic       hash_scan;
        logic       ptr_home;
        logic       rd;
        logic       ptr_step;
        logic       wr_val;
        logic       wr_new;
        logic       erase_start;
        logic       move;
        logic       erase_end;
        logic       res_load;
        logic [1:0] res_status;
        logic       res_hit;
        logic       res_fv;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       req_zero;
        logic       kd_zero;
        logic       kd_match;
        logic       cnt_last;
        logic       clr_last;
        logic       at_limit;
        logic       hash_valid;
        logic       shift_ok;
    } sts_t;

endpackage

FILE: rtl/lph_hash.sv
// ----------------------------------------------------------------------------
// lph_hash
// Five stage splitmix64 finalizer; 64-bit products built from 32x32 parts.
// ----------------------------------------------------------------------------
module lph_hash #(
    parameter int SLOTS = lph_pkg::SLOTS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [63:0]              key,
    output logic                     valid,
    output logic [$clog2(SLOTS)-1:0] slot
);
    localparam int AW = $clog2(SLOTS);

    logic [4:0]  v_reg;
    logic [63:0] z0_reg, z1_reg;
    logic [63:0] a0_reg, b0_reg;
    logic [31:0] a1_reg, a2_reg, b1_reg, b2_reg;
    logic [AW-1:0] slot_reg;
    logic [63:0] m1, m2, z2;
    logic [63:0] p01, p02, p11, p12;

    assign p01 = 64'(z0_reg[31:0]) * 64'(lph_pkg::MIX_C1[63:32]);
    assign p02 = 64'(z0_reg[63:32]) * 64'(lph_pkg::MIX_C1[31:0]);
    assign p11 = 64'(z1_reg[31:0]) * 64'(lph_pkg::MIX_C2[63:32]);
    assign p12 = 64'(z1_reg[63:32]) * 64'(lph_pkg::MIX_C2[31:0]);
    assign m1  = a0_reg + {a1_reg + a2_reg, 32'd0};
    assign m2  = b0_reg + {b1_reg + b2_reg, 32'd0};
    assign z2  = m2 ^ (m2 >> 31);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[3:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        z0_reg   <= key ^ (key >> 30);
        a0_reg   <= 64'(z0_reg[31:0]) * 64'(lph_pkg::MIX_C1[31:0]);
        a1_reg   <= p01[31:0];
        a2_reg   <= p02[31:0];
        z1_reg   <= m1 ^ (m1 >> 27);
        b0_reg   <= 64'(z1_reg[31:0]) * 64'(lph_pkg::MIX_C2[31:0]);
        b1_reg   <= p11[31:0];
        b2_reg   <= p12[31:0];
        slot_reg <= z2[AW-1:0];
    end

    assign valid = v_reg[4];
    assign slot  = slot_reg;

endmodule

FILE: rtl/lph_datapath.sv
// ----------------------------------------------------------------------------
// lph_datapath
// Slot stores, pointers, counters, hash unit and result registers.
// ----------------------------------------------------------------------------
module lph_datapath #(
    parameter int SLOTS = lph_pkg::SLOTS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lph_pkg::LIMIT_W-1:0]    cfg_wdata,
    input  lph_pkg::req_t                  req,
    input  lph_pkg::cmd_t                  cmd,
    output lph_pkg::sts_t                  sts,
    output lph_pkg::rsp_t                  rsp
);
    localparam int AW = $clog2(SLOTS);
    localparam int LW = AW + 1;

    logic [63:0] key_mem [SLOTS];
    logic [31:0] val_mem [SLOTS];

    lph_pkg::req_t req_reg;
    lph_pkg::rsp_t res_reg, rsp_reg;
    logic [AW-1:0] ptr_reg, gap_reg, cnt_reg;
    logic [LW-1:0] live_reg;
    logic [lph_pkg::LIMIT_W-1:0] limit_reg;
    logic [63:0] kd_reg;
    logic [31:0] vd_reg;

    logic          hash_start, hash_valid;
    logic [63:0]   hash_key;
    logic [AW-1:0] hash_slot;
    logic          kw_en, vw_en;
    logic [AW-1:0] kw_addr, vw_addr;
    logic [63:0]   kw_data;
    logic [31:0]   vw_data;
    logic [31:0]   lim32;
    logic [AW-1:0] dist_home, dist_gap;

    assign hash_start = cmd.hash_req | cmd.hash_scan;
    assign hash_key   = cmd.hash_scan ? kd_reg : req_reg.key;

    lph_hash #(.SLOTS(SLOTS)) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (hash_key),
        .valid (hash_valid),
        .slot  (hash_slot)
    );

    always_comb
    begin
        kw_en   = 1'b0;
        kw_addr = ptr_reg;
        kw_data = '0;
        vw_en   = 1'b0;
        vw_addr = ptr_reg;
        vw_data = req_reg.value;
        if (cmd.clr_wr)
        begin
            kw_en = 1'b1;
        end
        if (cmd.wr_new)
        begin
            kw_en   = 1'b1;
            kw_data = req_reg.key;
            vw_en   = 1'b1;
        end
        if (cmd.wr_val)
        begin
            vw_en = 1'b1;
        end
        if (cmd.move)
        begin
            kw_en   = 1'b1;
            kw_addr = gap_reg;
            kw_data = kd_reg;
            vw_en   = 1'b1;
            vw_addr = gap_reg;
            vw_data = vd_reg;
        end
        if (cmd.erase_end)
        begin
            kw_en   = 1'b1;
            kw_addr = gap_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (kw_en)
        begin
            key_mem[kw_addr] <= kw_data;
        end
        if (cmd.rd)
        begin
            kd_reg <= key_mem[ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (vw_en)
        begin
            val_mem[vw_addr] <= vw_data;
        end
        if (cmd.rd)
        begin
            vd_reg <= val_mem[ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            cnt_reg   <= '0;
            live_reg  <= '0;
            limit_reg <= lph_pkg::LIMIT_W'(lph_pkg::ENTRY_LIMIT_RESET);
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (cmd.ptr_home)
            begin
                ptr_reg <= hash_slot;
                cnt_reg <= '0;
            end
            else if (cmd.erase_start)
            begin
                ptr_reg <= ptr_reg + 1'b1;
                cnt_reg <= '0;
            end
            else if (cmd.ptr_step || cmd.clr_wr)
            begin
                ptr_reg <= ptr_reg + 1'b1;
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.wr_new)
            begin
                live_reg <= live_reg + 1'b1;
            end
            else if (cmd.erase_end && live_reg != '0)
            begin
                live_reg <= live_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req;
        end
        if (cmd.erase_start)
        begin
            gap_reg <= ptr_reg;
        end
        else if (cmd.move)
        begin
            gap_reg <= ptr_reg;
        end
        if (cmd.res_load)
        begin
            res_reg.status      <= cmd.res_status;
            res_reg.hit         <= cmd.res_hit;
            res_reg.found_value <= cmd.res_fv ? vd_reg : 32'd0;
        end
        if (cmd.out_load)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign lim32 = (32'(limit_reg) > 32'(SLOTS - 1)) ? 32'(SLOTS - 1) : 32'(limit_reg);
    assign dist_home = ptr_reg - hash_slot;
    assign dist_gap  = ptr_reg - gap_reg;

    assign sts.func       = req_reg.func;
    assign sts.req_zero   = (req_reg.key == 64'd0);
    assign sts.kd_zero    = (kd_reg == 64'd0);
    assign sts.kd_match   = (kd_reg == req_reg.key);
    assign sts.cnt_last   = &cnt_reg;
    assign sts.clr_last   = &ptr_reg;
    assign sts.at_limit   = (32'(live_reg) >= lim32);
    assign sts.hash_valid = hash_valid;
    assign sts.shift_ok   = (dist_home >= dist_gap);

    assign rsp = rsp_reg;

endmodule

FILE: rtl/lph_ctrl.sv
// ----------------------------------------------------------------------------
// lph_ctrl
// Sequencer: clear sweep, probe walk, insert, backward-shift removal.
// ----------------------------------------------------------------------------
module lph_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    input  lph_pkg::sts_t sts,
    output lph_pkg::cmd_t cmd
);
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_HASH   = 4'd3;
    localparam logic [3:0] S_PRD    = 4'd4;
    localparam logic [3:0] S_PCHK   = 4'd5;
    localparam logic [3:0] S_ERD    = 4'd6;
    localparam logic [3:0] S_ECHK   = 4'd7;
    localparam logic [3:0] S_EHASH  = 4'd8;
    localparam logic [3:0] S_EEND   = 4'd9;
    localparam logic [3:0] S_RESP   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       ov_reg, ov_next;
    logic       miss;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = ov_reg;
    assign miss      = sts.kd_zero || (!sts.kd_match && sts.cnt_last);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.req_zero)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = lph_pkg::ST_ZERO;
                    state_next     = S_RESP;
                end
                else if (sts.func != lph_pkg::FN_LOOKUP && sts.func != lph_pkg::FN_INSERT
                         && sts.func != lph_pkg::FN_REMOVE)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = lph_pkg::ST_DONE;
                    state_next     = S_RESP;
                end
                else
                begin
                    cmd.hash_req = 1'b1;
                    state_next   = S_HASH;
                end
            end
            S_HASH:
            begin
                if (sts.hash_valid)
                begin
                    cmd.ptr_home = 1'b1;
                    state_next   = S_PRD;
                end
            end
            S_PRD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                if (!sts.kd_zero && sts.kd_match)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = lph_pkg::ST_DONE;
                    cmd.res_hit    = 1'b1;
                    state_next     = S_RESP;
                    case (sts.func)
                        lph_pkg::FN_LOOKUP: cmd.res_fv = 1'b1;
                        lph_pkg::FN_INSERT: cmd.wr_val = 1'b1;
                        default:
                        begin
                            cmd.res_load    = 1'b0;
                            cmd.erase_start = 1'b1;
                            state_next      = S_ERD;
                        end
                    endcase
                end
                else if (miss)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = lph_pkg::ST_NOTFOUND;
                    state_next     = S_RESP;
                    if (sts.func == lph_pkg::FN_INSERT)
                    begin
                        if (sts.at_limit || !sts.kd_zero)
                        begin
                            cmd.res_status = lph_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.res_status = lph_pkg::ST_DONE;
                            cmd.wr_new     = 1'b1;
                        end
                    end
                end
                else
                begin
                    cmd.ptr_step = 1'b1;
                    state_next   = S_PRD;
                end
            end
            S_ERD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_ECHK;
            end
            S_ECHK:
            begin
                if (sts.kd_zero)
                begin
                    state_next = S_EEND;
                end
                else
                begin
                    cmd.hash_scan = 1'b1;
                    state_next    = S_EHASH;
                end
            end
            S_EHASH:
            begin
                if (sts.hash_valid)
                begin
                    cmd.move     = sts.shift_ok;
                    cmd.ptr_step = 1'b1;
                    state_next   = sts.cnt_last ? S_EEND : S_ERD;
                end
            end
            S_EEND:
            begin
                cmd.erase_end  = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_status = lph_pkg::ST_DONE;
                cmd.res_hit    = 1'b1;
                state_next     = S_RESP;
            end
            S_RESP:
            begin
                if (!ov_reg || rsp_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (cmd.out_load)
        begin
            ov_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

FILE: rtl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Reset: a sweep clears every slot of the store; requests held off.
// Flow: decode, hash, then a read and check per slot probed; zero key or
// unused func skips both. A remove then scans each occupied slot behind the
// hit (read, check, five stage home-slot hash), then clears the final gap.
// Throughput: one request at a time; the result register lets the next
// request enter while a response waits.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
    parameter int SLOTS = lph_pkg::SLOTS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [lph_pkg::LIMIT_W-1:0] cfg_wdata,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  lph_pkg::req_t               req,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output lph_pkg::rsp_t               rsp
);
    lph_pkg::cmd_t cmd;
    lph_pkg::sts_t sts;

    lph_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    lph_datapath #(.SLOTS(SLOTS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp       (rsp)
    );

endmodule

FILE: rtl/lph_checker.sv
// ----------------------------------------------------------------------------
// lph_checker
// Port-level checks on the hash table's requests and responses.
// ----------------------------------------------------------------------------
module lph_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input lph_pkg::rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken back to back");

    a_no_hit_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == lph_pkg::ST_NOTFOUND || rsp.status == lph_pkg::ST_FULL
        || rsp.status == lph_pkg::ST_ZERO) |-> !rsp.hit)
        else $error("hit flagged on failed request");

    a_value_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.found_value != 32'd0 |-> rsp.hit && rsp.status == lph_pkg::ST_DONE)
        else $error("value returned without hit");

endmodule

bind linear_probe_hash_table lph_checker u_lph_checker (.*);

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for linear_probe_hash_table. A shadow table with
// linear probing and backward-shift removal predicts each response. Requests
// come in random bursts; the response side stalls on its own pattern. The
// entry limit is rewritten between phases, when the block is idle.
// ----------------------------------------------------------------------------
module tb;

    localparam int NSLOT = 1024;
    localparam int WD_LIMIT = 200000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [lph_pkg::LIMIT_W-1:0] cfg_wdata;
    logic req_valid;
    logic req_ready;
    lph_pkg::req_t req;
    logic rsp_valid;
    logic rsp_ready;
    lph_pkg::rsp_t rsp;

    linear_probe_hash_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    logic [63:0] sh_key [NSLOT] = '{default: '0};
    logic [31:0] sh_val [NSLOT] = '{default: '0};
    int unsigned sh_count = 0;
    int unsigned sh_limit = lph_pkg::ENTRY_LIMIT_RESET;

    lph_pkg::req_t pending_reqs[$];
    lph_pkg::rsp_t expected_rsps[$];
    logic [63:0] used_keys[$];
    int errors = 0;
    int n_req = 0;
    int n_rsp = 0;
    int idle_cycles;
    int burst_left;
    int gap_left;
    int stall_mode;
    logic req_ready_s;

    function automatic int unsigned home_of(logic [63:0] k);
        logic [63:0] z;
        z = k;
        z = z ^ (z >> 30);
        z = z * 64'hbf58476d1ce4e5b9;
        z = z ^ (z >> 27);
        z = z * 64'h94d049bb133111eb;
        z = z ^ (z >> 31);
        return 32'(z[9:0]);
    endfunction

    function automatic bit find_slot(logic [63:0] k, output int unsigned where);
        int unsigned s;
        s = home_of(k);
        for (int n = 0; n < NSLOT; n++)
        begin
            if (sh_key[s] == 0)
            begin
                where = s;
                return 0;
            end
            if (sh_key[s] == k)
            begin
                where = s;
                return 1;
            end
            s = (s + 1) % NSLOT;
        end
        where = s;
        return 0;
    endfunction

    function automatic void shift_out(int unsigned slot);
        int unsigned gap;
        int unsigned scan;
        int unsigned h;
        gap = slot;
        scan = (gap + 1) % NSLOT;
        for (int n = 0; n < NSLOT && sh_key[scan] != 0; n++)
        begin
            h = home_of(sh_key[scan]);
            if (((scan - h) % NSLOT) >= ((scan - gap) % NSLOT))
            begin
                sh_key[gap] = sh_key[scan];
                sh_val[gap] = sh_val[scan];
                gap = scan;
            end
            scan = (scan + 1) % NSLOT;
        end
        sh_key[gap] = 0;
        if (sh_count > 0)
            sh_count--;
    endfunction

    function automatic lph_pkg::rsp_t table_apply(lph_pkg::req_t r);
        lph_pkg::rsp_t o;
        int unsigned slot;
        int unsigned lim;
        bit present;
        o = '0;
        lim = (sh_limit > NSLOT - 1) ? NSLOT - 1 : sh_limit;
        if (r.key == 0)
            o.status = lph_pkg::ST_ZERO;
        else if (r.func == lph_pkg::FN_LOOKUP || r.func == lph_pkg::FN_INSERT
                 || r.func == lph_pkg::FN_REMOVE)
        begin
            present = find_slot(r.key, slot);
            if (r.func == lph_pkg::FN_LOOKUP)
            begin
                if (present)
                begin
                    o.hit = 1'b1;
                    o.found_value = sh_val[slot];
                end
                else
                    o.status = lph_pkg::ST_NOTFOUND;
            end
            else if (r.func == lph_pkg::FN_INSERT)
            begin
                if (present)
                begin
                    o.hit = 1'b1;
                    sh_val[slot] = r.value;
                end
                else if (sh_count >= lim || sh_key[slot] != 0)
                    o.status = lph_pkg::ST_FULL;
                else
                begin
                    sh_key[slot] = r.key;
                    sh_val[slot] = r.value;
                    sh_count++;
                end
            end
            else
            begin
                if (present)
                begin
                    o.hit = 1'b1;
                    shift_out(slot);
                end
                else
                    o.status = lph_pkg::ST_NOTFOUND;
            end
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("tb: mismatch %s got %0h want %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick_key();
        int c;
        c = $urandom_range(0, 9);
        if (c < 7 && used_keys.size() > 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        if (c == 9)
            return 64'd0;
        return rand64();
    endfunction

    task automatic push_req(logic [1:0] f, logic [63:0] k, logic [31:0] v);
        lph_pkg::req_t r;
        r.func = f;
        r.key = k;
        r.value = v;
        pending_reqs.push_back(r);
        if (k != 0 && used_keys.size() < 300)
            used_keys.push_back(k);
    endtask

    task automatic drain_and_write(int unsigned lim);
        while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = lim[lph_pkg::LIMIT_W-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
        sh_limit = lim;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sampled request acceptance, seen by the driver at the next falling edge
    always @(posedge clk)
        req_ready_s <= req_ready;

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_valid  <= 1'b0;
            req        <= '0;
            rsp_ready  <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
            stall_mode <= 0;
        end
        else
        begin
            if (!req_valid || req_ready_s)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    req <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    req_valid <= 1'b0;
            end
            case (stall_mode)
                0: rsp_ready <= 1'b1;
                1: rsp_ready <= ($urandom_range(0, 3) != 0);
                default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
            if ($urandom_range(0, 99) == 0)
                stall_mode <= $urandom_range(0, 2);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if (req_valid && req_ready)
            begin
                expected_rsps.push_back(table_apply(req));
                n_req++;
            end
            if (rsp_valid && rsp_ready)
            begin
                n_rsp++;
                if (expected_rsps.size() == 0)
                    report_mismatch("unexpected response", 64'd0, 64'd0);
                else
                begin
                    lph_pkg::rsp_t w;
                    w = expected_rsps.pop_front();
                    if (rsp.status !== w.status)
                        report_mismatch("status", 64'(rsp.status), 64'(w.status));
                    if (rsp.hit !== w.hit)
                        report_mismatch("hit", 64'(rsp.hit), 64'(w.hit));
                    if (rsp.found_value !== w.found_value)
                        report_mismatch("found_value", 64'(rsp.found_value),
                                        64'(w.found_value));
                end
            end
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT)
            begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    initial
    begin
        logic [63:0] k;
        int unsigned limits [6];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed
        push_req(lph_pkg::FN_LOOKUP, 64'h1, 32'h0);
        push_req(lph_pkg::FN_INSERT, 64'h1, 32'hffff_ffff);
        push_req(lph_pkg::FN_LOOKUP, 64'h1, 32'h0);
        push_req(lph_pkg::FN_INSERT, 64'h1, 32'h1234_5678);
        push_req(lph_pkg::FN_LOOKUP, 64'h1, 32'h0);
        push_req(lph_pkg::FN_INSERT, '1, 32'h0);
        push_req(lph_pkg::FN_LOOKUP, '1, 32'hffff_ffff);
        push_req(lph_pkg::FN_INSERT, 64'h0, 32'h5);
        push_req(lph_pkg::FN_LOOKUP, 64'h0, 32'h5);
        push_req(lph_pkg::FN_REMOVE, 64'h0, 32'h5);
        push_req(2'd3, 64'h1, 32'h5);
        push_req(2'd3, 64'h0, 32'h5);
        push_req(lph_pkg::FN_REMOVE, 64'h2, 32'h0);
        push_req(lph_pkg::FN_REMOVE, 64'h1, 32'h0);
        push_req(lph_pkg::FN_LOOKUP, 64'h1, 32'h0);
        push_req(lph_pkg::FN_REMOVE, '1, 32'h0);
        push_req(lph_pkg::FN_LOOKUP, '1, 32'h0);
        drain_and_write(1);
        push_req(lph_pkg::FN_INSERT, 64'h10, 32'ha);
        push_req(lph_pkg::FN_INSERT, 64'h11, 32'hb);
        push_req(lph_pkg::FN_LOOKUP, 64'h11, 32'h0);
        push_req(lph_pkg::FN_REMOVE, 64'h10, 32'h0);
        drain_and_write(0);
        push_req(lph_pkg::FN_INSERT, 64'h12, 32'hc);
        push_req(lph_pkg::FN_LOOKUP, 64'h12, 32'h0);

        // random phases across limits
        limits[0] = 1023; limits[1] = 5; limits[2] = 64;
        limits[3] = 1023; limits[4] = 300; limits[5] = 700;
        for (int p = 0; p < 6; p++)
        begin
            drain_and_write(limits[p]);
            used_keys.delete();
            for (int i = 0; i < 80; i++)
            begin
                k = pick_key();
                push_req($urandom_range(0, 9) < 9 ? 2'($urandom_range(0, 2)) : 2'd3, k,
                         $urandom());
            end
        end
        // fill run: many inserts, then removes and lookups, to force long chains
        drain_and_write(1023);
        used_keys.delete();
        for (int i = 0; i < 120; i++)
            push_req(lph_pkg::FN_INSERT, rand64(), $urandom());
        for (int i = 0; i < 120; i++)
            push_req(lph_pkg::FN_REMOVE, used_keys[$urandom_range(0, used_keys.size() - 1)],
                     32'd0);
        for (int i = 0; i < 60; i++)
            push_req(lph_pkg::FN_LOOKUP, used_keys[i], 32'd0);

        while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("tb: %0d requests sent, %0d responses checked", n_req, n_rsp);
        $display("tb: limits 0, 1, 5, 64, 300, 700 and 1023 exercised");
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
